// ===== src/ack_retransmit_tracker_macros.svh =====
// Assertion macros used by the tracker sequencer RTL.
`ifndef ACK_RETRANSMIT_TRACKER_MACROS_SVH
`define ACK_RETRANSMIT_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property while out of reset.
`define ART_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tracker assertion violated");

// Check a property at every edge, reset included.
`define ART_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tracker assertion violated");

`else

`define ART_ASSERT(lbl, clk, rst_n, prop)
`define ART_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== src/art_pkg.sv =====
// Types and constants of the acknowledgement retransmit tracker.
package art_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned IVL_W   = 16;
  localparam int unsigned OIDX_W  = 4;
  localparam int unsigned STEP_W  = IVL_W + CNT_W;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [IVL_W-1:0] IVL_RESET = 16'd1000;

  // Register offsets
  localparam logic [APB_AW-1:0] REG_RETRY_INTERVAL = 3'd0;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_ACK    = 2'd1,
    OP_TIME   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TIME_W-1:0] now_ms;
    logic [ADDR_W-1:0] frame_source;
    logic [ADDR_W-1:0] frame_destination;
    logic [CRC_W-1:0]  frame_crc;
    logic              ack_requested;
    logic [TAG_W-1:0]  frame_tag;
  } in_word_t;

  typedef struct packed {
    logic [TAG_W-1:0]  resend_tag;
    logic [OIDX_W-1:0] entry_index;
    logic [CNT_W-1:0]  send_count;
    logic              last;
  } out_word_t;

  // One stack entry; count of zero marks a free entry
  typedef struct packed {
    logic [ADDR_W-1:0] source;
    logic [ADDR_W-1:0] destination;
    logic [CRC_W-1:0]  crc;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] expiry;
    logic [CNT_W-1:0]  count;
  } entry_t;

  // Memory commands from the sequencer
  typedef struct packed {
    logic push;
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== src/art_chan_if.sv =====
// Valid/ready channel carrying one word per handshake.
interface art_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/art_entry_mem.sv =====
// Entry memory: circular shift stack with one read and one write port.
module art_entry_mem #(
  parameter int unsigned ENTRIES = 4,
  parameter int unsigned IW      = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  art_pkg::mem_ctl_t     ctl_i,
  input  logic [IW-1:0]         rd_idx_i,
  input  logic [IW-1:0]         wr_idx_i,
  input  art_pkg::entry_t       wr_data_i,
  output art_pkg::entry_t       rd_data_o
);

  art_pkg::entry_t mem_q [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] rd_phys, wr_phys, wa;
  art_pkg::entry_t rd_q;
  logic rd_vld_q;

  // Logical stack position to physical row
  function automatic logic [IW-1:0] to_phys(logic [IW-1:0] head, logic [IW-1:0] idx);
    logic [IW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (IW+1)'(ENTRIES)) begin
      sum = sum - (IW+1)'(ENTRIES);
    end
    return sum[IW-1:0];
  endfunction

  // A push moves the top one row back; the oldest row is overwritten
  always_comb begin
    if (head_q == '0) begin
      head_d = IW'(ENTRIES - 1);
    end else begin
      head_d = head_q - 1'b1;
    end
  end

  assign rd_phys = to_phys(head_q, rd_idx_i);
  assign wr_phys = to_phys(head_q, wr_idx_i);
  assign wa      = ctl_i.push ? head_d : wr_phys;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.push) begin
        head_q <= head_d;
      end
      if (ctl_i.push || ctl_i.wr_en) begin
        vld_q[wa] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_phys];
      end
    end
  end

  // Storage rows and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.push || ctl_i.wr_en) begin
      mem_q[wa] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_phys];
    end
  end

  // Rows never written read as the reset value
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== src/art_ctrl.sv =====
// Sequencer: walks the stack for acks and time checks and stages resend words.
`include "ack_retransmit_tracker_macros.svh"

module art_ctrl #(
  parameter int unsigned ENTRIES = 4,
  parameter int unsigned IW      = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [art_pkg::IVL_W-1:0]   interval_i,
  art_chan_if.sink                    in_i,
  art_chan_if.source                  out_o,
  output art_pkg::mem_ctl_t           mem_ctl_o,
  output logic [IW-1:0]               rd_idx_o,
  output logic [IW-1:0]               wr_idx_o,
  output art_pkg::entry_t             wr_data_o,
  input  art_pkg::entry_t             rd_data_i
);

  art_pkg::state_e state_q, state_d;
  logic [IW-1:0] idx_q;
  logic time_q;
  logic [art_pkg::ADDR_W-1:0] src_q, dst_q;
  logic [art_pkg::CRC_W-1:0]  crc_q;
  logic [art_pkg::TIME_W-1:0] now_q;
  logic pend_vld_q, out_vld_q;
  art_pkg::out_word_t pend_q, out_q;

  logic accept, is_scan_op, is_push;
  logic is_last, ack_hit, expired, emit, stall, advance, out_free;
  logic move_scan, move_flush;
  logic [art_pkg::STEP_W-1:0] step;
  logic [art_pkg::CNT_W-1:0] cnt_inc;
  art_pkg::entry_t mod_entry, rec_entry;
  art_pkg::out_word_t new_word;

  assign accept = in_i.valid && in_i.ready;

  // Decode the incoming operation
  always_comb begin
    is_scan_op = 1'b0;
    is_push    = 1'b0;
    unique case (in_i.data.operation)
      art_pkg::OP_RECORD: is_push    = in_i.data.ack_requested;
      art_pkg::OP_ACK:    is_scan_op = 1'b1;
      art_pkg::OP_TIME:   is_scan_op = 1'b1;
      default:            is_scan_op = 1'b0;
    endcase
  end

  // Per-entry evaluation on the registered read word
  assign is_last  = (idx_q == IW'(ENTRIES - 1));
  assign ack_hit  = (rd_data_i.count != '0) && (rd_data_i.destination == src_q) &&
                    (rd_data_i.source == dst_q) && (rd_data_i.crc == crc_q);
  assign expired  = (rd_data_i.count != '0) && (rd_data_i.expiry < now_q);
  assign step     = art_pkg::STEP_W'(interval_i) * art_pkg::STEP_W'(rd_data_i.count);
  assign cnt_inc  = rd_data_i.count + 1'b1;
  assign out_free = !out_vld_q || out_o.ready;

  assign emit       = (state_q == art_pkg::ST_SCAN) && time_q && expired;
  assign stall      = emit && pend_vld_q && !out_free;
  assign advance    = (state_q == art_pkg::ST_SCAN) && !stall;
  assign move_scan  = emit && pend_vld_q && !stall;
  assign move_flush = (state_q == art_pkg::ST_FLUSH) && pend_vld_q && out_free;

  // Rewritten entry: reschedule on time check, free on ack
  always_comb begin
    mod_entry = rd_data_i;
    if (time_q) begin
      mod_entry.expiry = now_q + art_pkg::TIME_W'(step);
      mod_entry.count  = cnt_inc;
    end else begin
      mod_entry.expiry = '0;
      mod_entry.count  = '0;
    end
  end

  // New top entry of a record
  always_comb begin
    rec_entry.source      = in_i.data.frame_source;
    rec_entry.destination = in_i.data.frame_destination;
    rec_entry.crc         = in_i.data.frame_crc;
    rec_entry.tag         = in_i.data.frame_tag;
    rec_entry.expiry      = in_i.data.now_ms + art_pkg::TIME_W'(interval_i);
    rec_entry.count       = art_pkg::CNT_W'(1);
  end

  always_comb begin
    new_word.resend_tag  = rd_data_i.tag;
    new_word.entry_index = art_pkg::OIDX_W'(idx_q);
    new_word.send_count  = cnt_inc;
    new_word.last        = 1'b0;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      art_pkg::ST_IDLE: begin
        if (accept && is_scan_op) begin
          state_d = art_pkg::ST_SCAN;
        end
      end
      art_pkg::ST_SCAN: begin
        if (advance && is_last) begin
          state_d = time_q ? art_pkg::ST_FLUSH : art_pkg::ST_IDLE;
        end
      end
      art_pkg::ST_FLUSH: begin
        if (!pend_vld_q || out_free) begin
          state_d = art_pkg::ST_IDLE;
        end
      end
      default: state_d = art_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and memory commands
  always_comb begin
    in_i.ready      = (state_q == art_pkg::ST_IDLE);
    mem_ctl_o.push  = accept && is_push;
    mem_ctl_o.rd_en = (accept && is_scan_op) || (advance && !is_last);
    mem_ctl_o.wr_en = advance && (time_q ? expired : ack_hit);
    rd_idx_o        = (state_q == art_pkg::ST_IDLE) ? '0 : IW'(idx_q + 1'b1);
    wr_idx_o        = idx_q;
    wr_data_o       = (state_q == art_pkg::ST_IDLE) ? rec_entry : mod_entry;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= art_pkg::ST_IDLE;
      idx_q      <= '0;
      time_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        idx_q  <= '0;
        time_q <= (in_i.data.operation == art_pkg::OP_TIME);
      end else if (advance && !is_last) begin
        idx_q <= IW'(idx_q + 1'b1);
      end
      // Held resend word: its last flag is known only when the next one shows
      if (advance && emit) begin
        pend_vld_q <= 1'b1;
      end else if (move_flush) begin
        pend_vld_q <= 1'b0;
      end
      if (move_scan || move_flush) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q <= in_i.data.frame_source;
      dst_q <= in_i.data.frame_destination;
      crc_q <= in_i.data.frame_crc;
      now_q <= in_i.data.now_ms;
    end
    if (advance && emit) begin
      pend_q <= new_word;
    end
    if (move_scan) begin
      out_q <= pend_q;
    end else if (move_flush) begin
      out_q <= '{resend_tag:  pend_q.resend_tag,
                 entry_index: pend_q.entry_index,
                 send_count:  pend_q.send_count,
                 last:        1'b1};
    end
  end

  // Nothing is held back once the block is idle
  `ART_ASSERT_ALWAYS(a_idle_no_pend, clk_i, (state_q == art_pkg::ST_IDLE) |-> !pend_vld_q)
  // Read and write-back of one cycle never touch the same entry
  `ART_ASSERT(a_no_rw_clash, clk_i, rst_ni, (mem_ctl_o.rd_en && mem_ctl_o.wr_en) |-> (rd_idx_o != wr_idx_o))
  // An acknowledgement walk never produces resend words
  `ART_ASSERT(a_ack_silent, clk_i, rst_ni, ((state_q == art_pkg::ST_SCAN) && !time_q) |-> !pend_vld_q)
  // The final word leaves as soon as the output stage has room
  `ART_ASSERT(a_flush_done, clk_i, rst_ni, ((state_q == art_pkg::ST_FLUSH) && out_free) |=> (state_q == art_pkg::ST_IDLE))

endmodule

// ===== src/ack_retransmit_tracker.sv =====
// Acknowledgement retransmit tracker: top level with register port.
// Tracks up to ENTRIES sent frames awaiting acknowledgement in a single-port-read
// entry memory organized as a circular shift stack. Acknowledgement words and
// time checks walk the entries one per cycle, a time check pausing while the
// output side stalls, through the memory's single read port, writing changed
// entries back behind the read; no new word is taken until the block is idle.
// Resend words come out in stack order, the final one of a time check flagged
// with last. Reset state is held by per-entry valid bits, so no clearing pass is
// needed. retry_interval_ms lives at byte address 0 of the register port.
module ack_retransmit_tracker #(
  parameter int unsigned ENTRIES = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  art_chan_if.sink                    in_i,
  art_chan_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [art_pkg::APB_AW-1:0]  paddr,
  input  logic [art_pkg::APB_DW-1:0]  pwdata,
  output logic [art_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [art_pkg::IVL_W-1:0] interval_q;
  logic reg_hit;
  art_pkg::mem_ctl_t mem_ctl;
  logic [IW-1:0] rd_idx, wr_idx;
  art_pkg::entry_t wr_data, rd_data;

  // Register port
  assign pready  = 1'b1;
  assign reg_hit = (paddr == art_pkg::REG_RETRY_INTERVAL);
  assign prdata  = reg_hit ? art_pkg::APB_DW'(interval_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= art_pkg::IVL_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      interval_q <= pwdata[art_pkg::IVL_W-1:0];
    end
  end

  art_ctrl #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .interval_i (interval_q),
    .in_i       (in_i),
    .out_o      (out_o),
    .mem_ctl_o  (mem_ctl),
    .rd_idx_o   (rd_idx),
    .wr_idx_o   (wr_idx),
    .wr_data_o  (wr_data),
    .rd_data_i  (rd_data)
  );

  art_entry_mem #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_idx_i  (rd_idx),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the acknowledgement retransmit tracker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import art_pkg::*;

  localparam int          ENTRIES       = 4;
  localparam int          RESET_CYCLES  = 6;
  localparam int          SETTLE_CYCLES = 2 * ENTRIES + 8;
  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          PRINT_LIMIT   = 30;
  localparam int          RECENT_FRAMES = 8;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  art_chan_if #(.word_t(in_word_t))  in_ch ();
  art_chan_if #(.word_t(out_word_t)) out_ch ();

  ack_retransmit_tracker #(
    .ENTRIES (ENTRIES)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Words waiting for the driver, resends predicted but not yet seen
  in_word_t           words_waiting [$];
  out_word_t          resends_due [$];

  // Tracker state as the testbench predicts it
  entry_t             tracked [ENTRIES];
  logic [IVL_W-1:0]   interval_ms;

  // Stimulus bookkeeping
  logic [TIME_W-1:0]  clock_ms;
  logic [ADDR_W-1:0]  sent_src [RECENT_FRAMES];
  logic [ADDR_W-1:0]  sent_dst [RECENT_FRAMES];
  logic [CRC_W-1:0]   sent_crc [RECENT_FRAMES];
  int                 sent_n;

  int                 idle_pct    = 20;
  int                 stall_pct   = 20;
  int                 error_count = 0;
  int                 cycle_count = 0;
  logic               in_taken    = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("[cycle %0d] ERROR %s", cycle_count, msg);
  endtask

  // Apply one accepted word to the predicted stack; queue the resends it causes
  task automatic advance_tracker(input in_word_t w);
    out_word_t          hits [ENTRIES];
    int                 n;
    logic [TIME_W-1:0]  step;
    n = 0;
    case (w.operation)
      OP_RECORD: begin
        if (w.ack_requested) begin
          for (int k = ENTRIES - 1; k > 0; k--) tracked[k] = tracked[k-1];
          tracked[0].source      = w.frame_source;
          tracked[0].destination = w.frame_destination;
          tracked[0].crc         = w.frame_crc;
          tracked[0].tag         = w.frame_tag;
          tracked[0].expiry      = w.now_ms + interval_ms;
          tracked[0].count       = CNT_W'(1);
        end
      end
      OP_ACK: begin
        // ack comes back with addresses swapped
        for (int k = 0; k < ENTRIES; k++) begin
          if (tracked[k].count != '0 && tracked[k].destination == w.frame_source &&
              tracked[k].source == w.frame_destination && tracked[k].crc == w.frame_crc) begin
            tracked[k].count  = '0;
            tracked[k].expiry = '0;
          end
        end
      end
      OP_TIME: begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (tracked[k].count != '0 && tracked[k].expiry < w.now_ms) begin
            step               = interval_ms * tracked[k].count;
            tracked[k].expiry  = w.now_ms + step;
            tracked[k].count   = tracked[k].count + 1'b1;
            hits[n].resend_tag  = tracked[k].tag;
            hits[n].entry_index = OIDX_W'(k);
            hits[n].send_count  = tracked[k].count;
            hits[n].last        = 1'b0;
            n++;
          end
        end
        for (int i = 0; i < n; i++) begin
          if (i == n - 1) hits[i].last = 1'b1;
          resends_due.push_back(hits[i]);
        end
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  task automatic check_resend(input out_word_t got);
    out_word_t want;
    if (resends_due.size() == 0) begin
      flag_error($sformatf("resend with nothing pending: tag %0d index %0d count %0d",
                           got.resend_tag, got.entry_index, got.send_count));
    end else begin
      want = resends_due.pop_front();
      if (got.resend_tag != want.resend_tag)
        flag_error($sformatf("resend_tag got %0d want %0d", got.resend_tag, want.resend_tag));
      if (got.entry_index != want.entry_index)
        flag_error($sformatf("entry_index got %0d want %0d", got.entry_index, want.entry_index));
      if (got.send_count != want.send_count)
        flag_error($sformatf("send_count got %0d want %0d", got.send_count, want.send_count));
      if (got.last != want.last)
        flag_error($sformatf("last got %0b want %0b", got.last, want.last));
    end
  endtask

  // Driver: one word per handshake, random gaps; random stalls on the result side
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (!in_ch.valid || in_taken) begin
      if (words_waiting.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= words_waiting.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted words, check accepted resends
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) check_resend(out_ch.data);
      if (in_ch.valid && in_ch.ready) advance_tracker(in_ch.data);
    end
  end

  task automatic queue_word(input logic [1:0] op, input logic [TIME_W-1:0] now,
                            input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                            input logic [CRC_W-1:0] crc, input logic ack,
                            input logic [TAG_W-1:0] tag);
    in_word_t w;
    w.operation         = op;
    w.now_ms            = now;
    w.frame_source      = src;
    w.frame_destination = dst;
    w.frame_crc         = crc;
    w.ack_requested     = ack;
    w.frame_tag         = tag;
    words_waiting.push_back(w);
  endtask

  // Block idle: everything sent, every resend seen, last scan finished
  task automatic wait_idle();
    while (words_waiting.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (resends_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the retry interval, then read it back
  task automatic set_interval(input logic [IVL_W-1:0] value);
    logic [APB_DW-1:0] readback;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_RETRY_INTERVAL;
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    interval_ms = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback != APB_DW'(value))
      flag_error($sformatf("retry_interval_ms read %0d want %0d", readback, value));
  endtask

  // Mostly a few small addresses so frames collide, sometimes any address
  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(3) == 0) return ADDR_W'($urandom);
    return ADDR_W'($urandom_range(3));
  endfunction

  // Random traffic on a running millisecond clock; acks mostly answer recent frames
  task automatic random_traffic(input int count);
    int                 pick;
    int                 slot;
    logic [1:0]         op;
    logic [TIME_W-1:0]  now;
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [CRC_W-1:0]   crc;
    logic               ack;
    logic [TAG_W-1:0]   tag;
    repeat (count) begin
      pick = $urandom_range(99);
      src  = pick_address();
      dst  = pick_address();
      crc  = CRC_W'($urandom);
      tag  = TAG_W'($urandom);
      ack  = 1'($urandom_range(1));
      now  = $urandom;
      if (pick < 5) begin
        op = OP_UNUSED;
      end else if (pick < 42) begin
        op       = OP_RECORD;
        ack      = ($urandom_range(9) != 0);
        clock_ms = clock_ms + $urandom_range(interval_ms);
        now      = clock_ms;
        if (ack) begin
          sent_src[sent_n % RECENT_FRAMES] = src;
          sent_dst[sent_n % RECENT_FRAMES] = dst;
          sent_crc[sent_n % RECENT_FRAMES] = crc;
          sent_n++;
        end
      end else if (pick < 67) begin
        op = OP_ACK;
        if (sent_n != 0 && $urandom_range(9) < 8) begin
          slot = $urandom_range((sent_n < RECENT_FRAMES ? sent_n : RECENT_FRAMES) - 1);
          src  = sent_dst[slot];
          dst  = sent_src[slot];
          crc  = sent_crc[slot];
          // occasionally a corrupted CRC that must not clear anything
          if ($urandom_range(9) == 0) crc = crc ^ (CRC_W'(1) << $urandom_range(CRC_W - 1));
        end
      end else begin
        op = OP_TIME;
        if ($urandom_range(9) != 0) begin
          clock_ms = clock_ms + $urandom_range(2 * interval_ms);
          now      = clock_ms;
        end
      end
      queue_word(op, now, src, dst, crc, ack, tag);
    end
  endtask

  initial begin
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    interval_ms  = IVL_RESET;
    foreach (tracked[k]) tracked[k] = '0;
    clock_ms     = $urandom;
    sent_n       = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset interval of 1000
    queue_word(OP_TIME,   32'd0,         8'h00, 8'h00, 16'h0000, 1'b0, 8'h00);  // empty stack
    queue_word(OP_RECORD, 32'd5,         8'hAA, 8'h55, 16'hA5A5, 1'b0, 8'h11);  // no ack asked
    queue_word(OP_RECORD, 32'd0,         8'hFF, 8'h00, 16'hFFFF, 1'b1, 8'hFF);
    queue_word(OP_RECORD, 32'hFFFF_FFFF, 8'h00, 8'hFF, 16'h0000, 1'b1, 8'h00);  // expiry wraps
    queue_word(OP_RECORD, 32'd100,       8'h12, 8'h34, 16'hBEEF, 1'b1, 8'h5A);
    // expiry equal to now is not expired; only the wrapped one goes
    queue_word(OP_TIME,   32'd1000,      8'h00, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_word(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 8'hFF);
    queue_word(OP_ACK,    32'd0,         8'h34, 8'h12, 16'hBEEE, 1'b0, 8'h00);  // wrong CRC
    queue_word(OP_ACK,    32'd0,         8'h12, 8'h34, 16'hBEEF, 1'b0, 8'h00);  // not swapped
    queue_word(OP_ACK,    32'd0,         8'h34, 8'h12, 16'hBEEF, 1'b0, 8'h00);  // match
    queue_word(OP_TIME,   32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 1'b0, 8'h00);
    // two identical frames, one ack clears both
    queue_word(OP_RECORD, 32'd10,        8'h77, 8'h88, 16'h1234, 1'b1, 8'hA1);
    queue_word(OP_RECORD, 32'd10,        8'h77, 8'h88, 16'h1234, 1'b1, 8'hA2);
    queue_word(OP_ACK,    32'd0,         8'h88, 8'h77, 16'h1234, 1'b0, 8'h00);
    queue_word(OP_ACK,    32'd0,         8'h88, 8'h77, 16'h1234, 1'b0, 8'h00);  // free now
    queue_word(OP_TIME,   32'h8000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_word(OP_TIME,   32'h8000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'h00);
    queue_word(OP_TIME,   32'd0,         8'h00, 8'h00, 16'h0000, 1'b0, 8'h00);
    wait_idle();

    // Shortest interval, full stack resent until the counts wrap; no gaps or stalls
    set_interval(IVL_W'(1));
    idle_pct  = 0;
    stall_pct = 0;
    for (int i = 0; i < ENTRIES; i++)
      queue_word(OP_RECORD, $urandom_range(32'h7FFF_FFFF), pick_address(), pick_address(),
                 CRC_W'($urandom), 1'b1, TAG_W'($urandom));
    for (int i = 0; i < 256; i++)
      queue_word(OP_TIME, 32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 1'b0, 8'h00);
    wait_idle();
    idle_pct  = 20;
    stall_pct = 20;

    set_interval(IVL_W'(65535));
    random_traffic(50);
    wait_idle();

    set_interval(IVL_W'($urandom_range(65534, 2)));
    random_traffic(25);
    wait_idle();  // sender holds off until all resends are out
    random_traffic(25);
    wait_idle();

    set_interval(IVL_RESET);
    random_traffic(50);
    wait_idle();

    set_interval(IVL_W'(1));
    random_traffic(50);
    wait_idle();

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
